// ----- rtl/tgc_pkg.sv -----
// Shared constants, gesture codes and register types for the touch gesture classifier.
// No dependencies; every other file references this package by scoped names.
`default_nettype none

package tgc_pkg;

   localparam int COORD_BITS = 12;
   localparam int POS_BITS = 12;
   localparam int POS_USED_BITS = (COORD_BITS < POS_BITS) ? COORD_BITS : POS_BITS;
   localparam int TIME_BITS = 32;
   localparam int MS_BITS = 16;
   localparam int THR_BITS = 12;
   localparam int CMP_BITS = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;
   localparam int GEST_BITS = 3;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOVE_THR = 2'd2;

   localparam logic [MS_BITS-1:0] TAP_LIMIT_RESET = 16'd300;
   localparam logic [MS_BITS-1:0] LONG_PRESS_RESET = 16'd800;
   localparam logic [THR_BITS-1:0] MOVE_THR_RESET = 12'd10;

   localparam logic [GEST_BITS-1:0] GEST_NONE = 3'd0;
   localparam logic [GEST_BITS-1:0] GEST_TAP = 3'd1;
   localparam logic [GEST_BITS-1:0] GEST_LONG = 3'd2;
   localparam logic [GEST_BITS-1:0] GEST_DSTART = 3'd3;
   localparam logic [GEST_BITS-1:0] GEST_DMOVE = 3'd4;
   localparam logic [GEST_BITS-1:0] GEST_DEND = 3'd5;

   typedef struct packed {
      logic [MS_BITS-1:0] tap_limit_ms;
      logic [MS_BITS-1:0] long_press_ms;
      logic [THR_BITS-1:0] move_threshold;
   } cfg_type;

   typedef struct packed {
      logic touched;
      logic [POS_BITS-1:0] pos_x;
      logic [POS_BITS-1:0] pos_y;
      logic [TIME_BITS-1:0] now_ms;
   } poll_type;

endpackage

`default_nettype wire

// ----- rtl/tgc_if.sv -----
// Valid/ready channel interfaces for touch polls and gesture results.
// Depends on tgc_pkg for field widths.
`default_nettype none

interface tgc_req_if;
   logic valid;
   logic ready;
   logic touched;
   logic [tgc_pkg::POS_BITS-1:0] pos_x;
   logic [tgc_pkg::POS_BITS-1:0] pos_y;
   logic [tgc_pkg::TIME_BITS-1:0] now_ms;

   modport source (output valid, output touched, output pos_x, output pos_y,
                   output now_ms, input ready);
   modport sink (input valid, input touched, input pos_x, input pos_y,
                 input now_ms, output ready);
endinterface

interface tgc_rsp_if;
   logic valid;
   logic ready;
   logic [tgc_pkg::GEST_BITS-1:0] gesture;

   modport source (output valid, output gesture, input ready);
   modport sink (input valid, input gesture, output ready);
endinterface

`default_nettype wire

// ----- rtl/touch_gesture_classifier.sv -----
// Top level of the touch gesture classifier: config registers, poll register, result register.
// Depends on tgc_pkg, tgc_req_if / tgc_rsp_if and tgc_core.
//
//   channel  dir  beat payload                          handshake
//   req_chan in   touched, pos_x, pos_y, now_ms         valid/ready
//   rsp_chan out  gesture                               valid/ready
//   csr_*    in   csr_index, csr_wdata                  csr_we, no stall
//
// One poll per clock while rsp is not stalled; a req beat passes the poll register, then the
// result register, before rsp valid rises.
// Synchronous active-high reset clears valids, press state and loads register defaults.
// A stalled rsp holds the result register; the poll register then takes a beat only if it is empty.
`default_nettype none

module touch_gesture_classifier (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   tgc_req_if.sink                                   req_chan,
   tgc_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [tgc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tgc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   tgc_pkg::cfg_type                  cfg_ff;
   tgc_pkg::poll_type                 poll_ff;
   logic                              poll_valid_ff;
   logic                              out_valid_ff;
   logic [tgc_pkg::GEST_BITS-1:0]     gesture_ff;
   logic [tgc_pkg::GEST_BITS-1:0]     gesture_in;
   logic                              advance;
   logic                              req_fire;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !poll_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.gesture = gesture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_limit_ms <= tgc_pkg::TAP_LIMIT_RESET;
         cfg_ff.long_press_ms <= tgc_pkg::LONG_PRESS_RESET;
         cfg_ff.move_threshold <= tgc_pkg::MOVE_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tgc_pkg::CSR_TAP_LIMIT: cfg_ff.tap_limit_ms <= csr_wdata;
            tgc_pkg::CSR_LONG_PRESS: cfg_ff.long_press_ms <= csr_wdata;
            tgc_pkg::CSR_MOVE_THR:
               cfg_ff.move_threshold <= csr_wdata[tgc_pkg::THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            poll_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= poll_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         poll_ff.touched <= req_chan.touched;
         poll_ff.pos_x <= req_chan.pos_x;
         poll_ff.pos_y <= req_chan.pos_y;
         poll_ff.now_ms <= req_chan.now_ms;
      end
      if (advance && poll_valid_ff) begin
         gesture_ff <= gesture_in;
      end
   end

   tgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance && poll_valid_ff),
      .poll    (poll_ff),
      .cfg     (cfg_ff),
      .gesture (gesture_in)
   );

   a_gesture_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (gesture_ff <= tgc_pkg::GEST_DEND))
      else $error("gesture code out of range");

   a_poll_held: assert property (@(posedge clock) disable iff (reset)
      (poll_valid_ff && !advance) |=> (poll_valid_ff && $stable(poll_ff)))
      else $error("stalled poll lost");

   a_poll_moves: assert property (@(posedge clock) disable iff (reset)
      (poll_valid_ff && advance) |=> out_valid_ff)
      else $error("classified poll gave no result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !poll_valid_ff))
      else $error("valid set after reset");

endmodule

`default_nettype wire

// ----- rtl/tgc_core.sv -----
// Gesture decision logic and press tracking state; one registered poll per enabled cycle.
// Depends on tgc_pkg.
`default_nettype none

module tgc_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            enable,
   input  wire tgc_pkg::poll_type               poll,
   input  wire tgc_pkg::cfg_type                cfg,
   output logic [tgc_pkg::GEST_BITS-1:0]        gesture
);

   logic                               was_pressed_ff, was_pressed_in;
   logic                               dragging_ff, dragging_in;
   logic [tgc_pkg::COORD_BITS-1:0]     start_x_ff, start_x_in;
   logic [tgc_pkg::COORD_BITS-1:0]     start_y_ff, start_y_in;
   logic [tgc_pkg::TIME_BITS-1:0]      start_time_ff, start_time_in;

   logic [tgc_pkg::COORD_BITS-1:0]     cur_x, cur_y, dx, dy;
   logic [tgc_pkg::CMP_BITS-1:0]       dx_w, dy_w, thr_w;
   logic [tgc_pkg::TIME_BITS-1:0]      held;
   logic                               still, moved;

   assign cur_x = tgc_pkg::COORD_BITS'(poll.pos_x[tgc_pkg::POS_USED_BITS-1:0]);
   assign cur_y = tgc_pkg::COORD_BITS'(poll.pos_y[tgc_pkg::POS_USED_BITS-1:0]);
   assign dx = (cur_x >= start_x_ff) ? cur_x - start_x_ff : start_x_ff - cur_x;
   assign dy = (cur_y >= start_y_ff) ? cur_y - start_y_ff : start_y_ff - cur_y;
   assign dx_w = tgc_pkg::CMP_BITS'(dx);
   assign dy_w = tgc_pkg::CMP_BITS'(dy);
   assign thr_w = tgc_pkg::CMP_BITS'(cfg.move_threshold);
   assign held = poll.now_ms - start_time_ff;
   assign still = (dx_w < thr_w) && (dy_w < thr_w);
   assign moved = (dx_w > thr_w) || (dy_w > thr_w);

   always_comb begin
      gesture = tgc_pkg::GEST_NONE;
      was_pressed_in = poll.touched;
      dragging_in = dragging_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      start_time_in = start_time_ff;
      unique case ({poll.touched, was_pressed_ff})
         2'b10: begin
            start_x_in = cur_x;
            start_y_in = cur_y;
            start_time_in = poll.now_ms;
            dragging_in = 1'b0;
         end
         2'b11: begin
            priority if (!dragging_ff && (held > tgc_pkg::TIME_BITS'(cfg.long_press_ms))
                         && still) begin
               gesture = tgc_pkg::GEST_LONG;
            end else if (moved) begin
               if (!dragging_ff) begin
                  gesture = tgc_pkg::GEST_DSTART;
                  dragging_in = 1'b1;
               end else begin
                  gesture = tgc_pkg::GEST_DMOVE;
               end
            end else begin
               gesture = tgc_pkg::GEST_NONE;
            end
         end
         2'b01: begin
            priority if (dragging_ff) begin
               gesture = tgc_pkg::GEST_DEND;
            end else if (held < tgc_pkg::TIME_BITS'(cfg.tap_limit_ms)) begin
               gesture = tgc_pkg::GEST_TAP;
            end else begin
               gesture = tgc_pkg::GEST_NONE;
            end
            dragging_in = 1'b0;
            start_time_in = '0;
         end
         2'b00: begin
            gesture = tgc_pkg::GEST_NONE;
         end
         default: begin
            gesture = tgc_pkg::GEST_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff <= 1'b0;
         dragging_ff <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         start_time_ff <= '0;
      end else if (enable) begin
         was_pressed_ff <= was_pressed_in;
         dragging_ff <= dragging_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         start_time_ff <= start_time_in;
      end
   end

   a_drag_needs_press: assert property (@(posedge clock) disable iff (reset)
      dragging_ff |-> was_pressed_ff)
      else $error("dragging without a held press");

   a_dstart_sets_drag: assert property (@(posedge clock) disable iff (reset)
      (enable && gesture == tgc_pkg::GEST_DSTART) |=> dragging_ff)
      else $error("drag start did not set dragging");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (enable && !poll.touched) |=> (!dragging_ff && !was_pressed_ff))
      else $error("release left press state set");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for touch_gesture_classifier: a directed table of polls, then random gesture
// sequences under several register settings, checked beat by beat against a local predictor.
// Depends on tgc_pkg, tgc_req_if / tgc_rsp_if and the touch_gesture_classifier RTL.

module tb;

   typedef logic [tgc_pkg::GEST_BITS-1:0] gest_type;

   typedef struct {
      logic                           touched;
      logic [tgc_pkg::POS_BITS-1:0]   x;
      logic [tgc_pkg::POS_BITS-1:0]   y;
      logic [tgc_pkg::TIME_BITS-1:0]  ms;
      bit                             pinned;
      gest_type                       gesture;
   } plan_row_type;

   localparam logic [tgc_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_POLLS = 285;
   localparam int IDLE_PCT = 36;
   localparam int HOLD_OFF_CYCLES = 300;

   logic clock;
   logic reset;
   logic csr_we;
   logic [tgc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [tgc_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   tgc_req_if req_chan ();
   tgc_rsp_if rsp_chan ();

   touch_gesture_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and register copy
   logic [tgc_pkg::MS_BITS-1:0]    tap_ms = tgc_pkg::TAP_LIMIT_RESET;
   logic [tgc_pkg::MS_BITS-1:0]    hold_ms = tgc_pkg::LONG_PRESS_RESET;
   logic [tgc_pkg::THR_BITS-1:0]   slop = tgc_pkg::MOVE_THR_RESET;
   logic                           prev_touched = 1'b0;
   logic [tgc_pkg::COORD_BITS-1:0] anchor_x = '0;
   logic [tgc_pkg::COORD_BITS-1:0] anchor_y = '0;
   logic [tgc_pkg::TIME_BITS-1:0]  anchor_ms = '0;
   logic                           in_drag = 1'b0;

   gest_type gesture_queue[$];
   int    error_count = 0;
   int    polls_sent = 0;
   int    cycle_count = 0;
   bit    steady = 1'b0;
   bit    hold_req = 1'b0;

   plan_row_type plan [24] = '{
      '{1'b0, 12'd0,    12'd0,    32'd0,          1'b1, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd4095, 12'd4095, 32'hFFFF_FFFF,  1'b1, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd100,  12'd100,  32'd1000,       1'b1, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd100,  12'd100,  32'd1800,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd100,  12'd100,  32'd1299,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4095, 12'd0,    32'd2000,       1'b1, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4095, 12'd0,    32'd2801,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4086, 12'd0,    32'd2900,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4085, 12'd0,    32'd2950,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4084, 12'd0,    32'd3000,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4000, 12'd4095, 32'd3100,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd4095, 12'd0,    32'd3200,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd0,    12'd0,    32'd3300,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd0,    12'd4095, 32'd5000,       1'b1, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd0,    12'd4095, 32'd5300,       1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd2048, 12'd2048, 32'hFFFF_FF00,  1'b1, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd2048, 12'd2058, 32'h0000_0100,  1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd2048, 12'd2059, 32'h0000_0200,  1'b0, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd2048, 12'd2059, 32'h0000_0250,  1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd10,   12'd10,   32'd100,        1'b1, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd10,   12'd10,   32'd50,         1'b0, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd10,   12'd10,   32'd100,        1'b1, tgc_pkg::GEST_NONE},
      '{1'b1, 12'd10,   12'd10,   32'd99,         1'b0, tgc_pkg::GEST_NONE},
      '{1'b0, 12'd10,   12'd10,   32'd399,        1'b0, tgc_pkg::GEST_NONE}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("tb: mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic gest_type classify_poll(input tgc_pkg::poll_type p);
      logic [tgc_pkg::COORD_BITS-1:0] px;
      logic [tgc_pkg::COORD_BITS-1:0] py;
      logic [tgc_pkg::COORD_BITS-1:0] dx;
      logic [tgc_pkg::COORD_BITS-1:0] dy;
      logic [tgc_pkg::TIME_BITS-1:0]  held;
      logic                           still;
      logic                           moved;
      gest_type                       g;
      px = tgc_pkg::COORD_BITS'(p.pos_x[tgc_pkg::POS_USED_BITS-1:0]);
      py = tgc_pkg::COORD_BITS'(p.pos_y[tgc_pkg::POS_USED_BITS-1:0]);
      dx = (px >= anchor_x) ? px - anchor_x : anchor_x - px;
      dy = (py >= anchor_y) ? py - anchor_y : anchor_y - py;
      held = p.now_ms - anchor_ms;
      still = (dx < slop) && (dy < slop);
      moved = (dx > slop) || (dy > slop);
      g = tgc_pkg::GEST_NONE;
      if (p.touched && !prev_touched) begin
         anchor_x = px;
         anchor_y = py;
         anchor_ms = p.now_ms;
         in_drag = 1'b0;
      end else if (p.touched) begin
         if (!in_drag && held > hold_ms && still) begin
            g = tgc_pkg::GEST_LONG;
         end else if (moved) begin
            g = in_drag ? tgc_pkg::GEST_DMOVE : tgc_pkg::GEST_DSTART;
            in_drag = 1'b1;
         end
      end else if (prev_touched) begin
         if (in_drag)
            g = tgc_pkg::GEST_DEND;
         else if (held < tap_ms)
            g = tgc_pkg::GEST_TAP;
         in_drag = 1'b0;
         anchor_ms = '0;
      end
      prev_touched = p.touched;
      return g;
   endfunction

   task automatic csr_write(input logic [tgc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [tgc_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         tgc_pkg::CSR_TAP_LIMIT:  tap_ms = data;
         tgc_pkg::CSR_LONG_PRESS: hold_ms = data;
         tgc_pkg::CSR_MOVE_THR:   slop = data[tgc_pkg::THR_BITS-1:0];
         default: ;
      endcase
   endtask

   // offer one poll; on the accepting edge, queue the gesture it must produce
   task automatic offer_poll(input tgc_pkg::poll_type p, input bit pinned,
                             input gest_type pinned_gest);
      gest_type g;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.touched <= p.touched;
      req_chan.pos_x <= p.pos_x;
      req_chan.pos_y <= p.pos_y;
      req_chan.now_ms <= p.now_ms;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      g = classify_poll(p);
      gesture_queue.push_back(pinned ? pinned_gest : g);
      polls_sent++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (gesture_queue.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [tgc_pkg::POS_BITS-1:0] near(
         input logic [tgc_pkg::POS_BITS-1:0] base);
      int d;
      case ($urandom_range(3))
         0: d = 0;
         1: d = (slop == 0) ? 0 : int'($urandom_range(int'(slop) - 1));
         2: d = int'(slop);
         default: d = int'($urandom_range(int'(slop) + 3));
      endcase
      if ($urandom_range(1)) d = -d;
      return tgc_pkg::POS_BITS'(int'(base) + d);
   endfunction

   function automatic logic [tgc_pkg::TIME_BITS-1:0] pick_delay();
      case ($urandom_range(4))
         0: return $urandom_range(200);
         1: return tap_ms + $urandom_range(2) - 1;
         2: return hold_ms + $urandom_range(2) - 1;
         3: return $urandom_range(70000);
         default: return $urandom;
      endcase
   endfunction

   task automatic play_gesture();
      tgc_pkg::poll_type p;
      logic [tgc_pkg::POS_BITS-1:0] x0;
      logic [tgc_pkg::POS_BITS-1:0] y0;
      logic [tgc_pkg::TIME_BITS-1:0] t0;
      int n;
      if ($urandom_range(99) < 15) begin
         p.touched = 1'($urandom_range(1));
         p.pos_x = tgc_pkg::POS_BITS'($urandom);
         p.pos_y = tgc_pkg::POS_BITS'($urandom);
         p.now_ms = $urandom;
         offer_poll(p, 1'b0, tgc_pkg::GEST_NONE);
      end else begin
         x0 = tgc_pkg::POS_BITS'($urandom);
         y0 = tgc_pkg::POS_BITS'($urandom);
         t0 = $urandom;
         p.touched = 1'b1;
         p.pos_x = x0;
         p.pos_y = y0;
         p.now_ms = t0;
         offer_poll(p, 1'b0, tgc_pkg::GEST_NONE);
         n = int'($urandom_range(10));
         repeat (n) begin
            p.pos_x = near(x0);
            p.pos_y = near(y0);
            p.now_ms = t0 + pick_delay();
            offer_poll(p, 1'b0, tgc_pkg::GEST_NONE);
         end
         if ($urandom_range(9) != 0) begin
            p.touched = 1'b0;
            p.pos_x = tgc_pkg::POS_BITS'($urandom);
            p.pos_y = tgc_pkg::POS_BITS'($urandom);
            p.now_ms = t0 + pick_delay();
            offer_poll(p, 1'b0, tgc_pkg::GEST_NONE);
         end
      end
   endtask

   task automatic run_phase(input logic [tgc_pkg::CSR_DATA_BITS-1:0] tap,
                            input logic [tgc_pkg::CSR_DATA_BITS-1:0] hold,
                            input logic [tgc_pkg::CSR_DATA_BITS-1:0] thr);
      int goal;
      goal = polls_sent + PHASE_POLLS;
      csr_write(tgc_pkg::CSR_TAP_LIMIT, tap);
      csr_write(tgc_pkg::CSR_LONG_PRESS, hold);
      csr_write(tgc_pkg::CSR_MOVE_THR, thr);
      while (polls_sent < goal) play_gesture();
      settle();
   endtask

   // result side: random back-pressure (none while steady), one long hold-off on request
   initial begin
      bit hold_served;
      int hold_left;
      gest_type want;
      hold_served = 1'b0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (gesture_queue.size() == 0) begin
               report_mismatch($sformatf("gesture beat %0d with no poll pending",
                                         rsp_chan.gesture));
            end else begin
               want = gesture_queue.pop_front();
               if (rsp_chan.gesture !== want)
                  report_mismatch($sformatf("gesture %0d, expected %0d",
                                            rsp_chan.gesture, want));
            end
         end
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (steady) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      tgc_pkg::poll_type p;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= tgc_pkg::CSR_TAP_LIMIT;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.touched <= 1'b0;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.now_ms <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed polls under reset register values
      foreach (plan[i]) begin
         p.touched = plan[i].touched;
         p.pos_x = plan[i].x;
         p.pos_y = plan[i].y;
         p.now_ms = plan[i].ms;
         offer_poll(p, plan[i].pinned, plan[i].gesture);
      end
      settle();

      run_phase(16'd0, 16'd0, 16'd0);
      run_phase(16'hFFFF, 16'hFFFF, 16'h0FFF);
      steady <= 1'b1;
      run_phase(tgc_pkg::TAP_LIMIT_RESET, tgc_pkg::LONG_PRESS_RESET,
                {4'h0, tgc_pkg::MOVE_THR_RESET});
      steady <= 1'b0;
      hold_req <= 1'b1;
      run_phase(tgc_pkg::CSR_DATA_BITS'($urandom_range(2000)),
                tgc_pkg::CSR_DATA_BITS'($urandom_range(3000)),
                tgc_pkg::CSR_DATA_BITS'($urandom_range(64)));
      csr_write(CSR_SPARE, tgc_pkg::CSR_DATA_BITS'($urandom));
      run_phase(tgc_pkg::CSR_DATA_BITS'($urandom), tgc_pkg::CSR_DATA_BITS'($urandom),
                tgc_pkg::CSR_DATA_BITS'($urandom));
      run_phase(tgc_pkg::CSR_DATA_BITS'($urandom_range(2000)),
                tgc_pkg::CSR_DATA_BITS'($urandom_range(3000)),
                tgc_pkg::CSR_DATA_BITS'($urandom_range(64)));

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
